@@ rtl/lpt_pkg.sv @@
// ----------------------------------------------------------------------------
// lpt_pkg
// Shared types and fixed field widths for the LIS patience-tails unit.
// ----------------------------------------------------------------------------
package lpt_pkg;

  // Fixed port widths
  localparam int SAMPLE_W = 32;
  localparam int LEN_W    = 11;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/lis_length_patience_tails_unit.sv @@
// Sequence: accept, first probe read issue, probe steps, table update, output load.
// Pace: a new sample is taken only after the last result is loaded, and an
//   unread result holds the unit; the single memory read port and the shared
//   probe compare set the pace.
// Reset: clears length, overflow and handshake state; the tail memory is not
//   cleared and needs no clearing pass, since only written entries are read.
// ----------------------------------------------------------------------------
// lis_length_patience_tails_unit
// Streaming longest strictly increasing subsequence length using a table of
// smallest tails searched by an iterative binary search.
// ----------------------------------------------------------------------------
module lis_length_patience_tails_unit import lpt_pkg::*; #(
  parameter int MAX_LEN    = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       start_req,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [LEN_W-1:0]           lis_length,
  output logic                       overflow
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(MAX_LEN);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

  state_t                state;
  state_t                state_next;
  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] sval;
  logic [CNT_W-1:0]      cnt;
  logic                  ovf;
  logic [CNT_W-1:0]      lo;
  logic [CNT_W-1:0]      hi;
  logic [CNT_W-1:0]      mid;
  logic                  rd_pend;
  logic [LEN_W-1:0]      len_view;

  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [VALUE_BITS-1:0] rd_data;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [CNT_W-1:0]      p_lo;
  logic [CNT_W-1:0]      p_hi;
  logic [CNT_W-1:0]      p_mid;
  logic                  p_more;
  logic                  out_load;

  // Sample as a VALUE_BITS signed value: low bits, or sign-extended when wider
  generate
    if (VALUE_BITS <= SAMPLE_W) begin : g_narrow
      assign sval = sample[VALUE_BITS-1:0];
    end else begin : g_wide
      assign sval = {{(VALUE_BITS - SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    end
  endgenerate

  // Length seen on the port, cut or padded to the port width
  generate
    if (CNT_W >= LEN_W) begin : g_len_cut
      assign len_view = cnt[LEN_W-1:0];
    end else begin : g_len_pad
      assign len_view = {{(LEN_W - CNT_W){1'b0}}, cnt};
    end
  endgenerate

  lpt_tail_mem #(
    .DEPTH (MAX_LEN),
    .WIDTH (VALUE_BITS),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lpt_probe #(
    .CNT_W      (CNT_W),
    .VALUE_BITS (VALUE_BITS)
  ) u_probe (
    .lo       (lo),
    .hi       (hi),
    .mid      (mid),
    .tail     (rd_data),
    .value    (value),
    .lo_next  (p_lo),
    .hi_next  (p_hi),
    .mid_next (p_mid),
    .more     (p_more)
  );

  assign in_ready = (state == ST_IDLE) && !rst;
  assign out_load = (state == ST_EMIT) && (!out_valid || out_ready);

  // Next state and memory control
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = p_mid[IDX_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = lo[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!rd_pend) begin
          // first probe sits at the middle of [0, hi)
          rd_addr = IDX_W'(hi >> 1);
          if (hi != '0) begin
            rd_en = 1'b1;
          end else begin
            state_next = ST_UPDATE;
          end
        end else if (p_more) begin
          rd_en = 1'b1;
        end else begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // replace the found tail (equal tail rewrites the same value) or append
        wr_en      = (lo < cnt) || (cnt < MAX_CNT);
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      ovf       <= 1'b0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      if ((state == ST_IDLE) && in_valid && start_req) begin
        cnt <= '0;
        ovf <= 1'b0;
      end
      if ((state == ST_UPDATE) && (lo == cnt)) begin
        if (cnt < MAX_CNT) begin
          cnt <= cnt + CNT_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && in_valid) begin
      value <= sval;
      lo    <= '0;
      hi    <= start_req ? '0 : cnt;
    end
    if (state == ST_SEARCH) begin
      if (!rd_pend) begin
        mid <= hi >> 1;
      end else begin
        lo  <= p_lo;
        hi  <= p_hi;
        mid <= p_mid;
      end
    end
    if (out_load) begin
      lis_length <= len_view;
      overflow   <= ovf;
    end
  end

`ifndef SYNTHESIS
  // Tail count never passes the table size
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= MAX_CNT)
    else $error("tail count above table size");

  // A pending probe always lies inside the live search window
  a_probe_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) && rd_pend |-> (lo <= mid) && (mid < hi) && (hi <= cnt))
    else $error("probe outside search window");

  // Tail count grows by one at a time or restarts at zero
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    cnt != $past(cnt) |-> (cnt == $past(cnt) + CNT_W'(1)) || (cnt == '0))
    else $error("tail count jumped");

  // A new result appears only from the output load step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMIT))
    else $error("result raised outside output step");
`endif

endmodule

@@ rtl/lpt_tail_mem.sv @@
// ----------------------------------------------------------------------------
// lpt_tail_mem
// Tail value store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpt_tail_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/lpt_probe.sv @@
// ----------------------------------------------------------------------------
// lpt_probe
// Binary search step: compares the fetched tail with the sample and picks
// the next search bounds and probe index.
// ----------------------------------------------------------------------------
module lpt_probe #(
  parameter int CNT_W      = 11,
  parameter int VALUE_BITS = 32
) (
  input  logic [CNT_W-1:0]      lo,
  input  logic [CNT_W-1:0]      hi,
  input  logic [CNT_W-1:0]      mid,
  input  logic [VALUE_BITS-1:0] tail,
  input  logic [VALUE_BITS-1:0] value,
  output logic [CNT_W-1:0]      lo_next,
  output logic [CNT_W-1:0]      hi_next,
  output logic [CNT_W-1:0]      mid_next,
  output logic                  more
);

  logic             less;
  logic [CNT_W-1:0] lo_r;
  logic [CNT_W-1:0] mid_r;
  logic [CNT_W-1:0] mid_l;

  // Both candidate probes come from registers only; the compare just selects
  always_comb begin
    less  = $signed(tail) < $signed(value);
    lo_r  = mid + CNT_W'(1);
    mid_r = lo_r + ((hi - lo_r) >> 1);
    mid_l = lo + ((mid - lo) >> 1);
    if (less) begin
      lo_next  = lo_r;
      hi_next  = hi;
      mid_next = mid_r;
      more     = lo_r < hi;
    end else begin
      lo_next  = lo;
      hi_next  = mid;
      mid_next = mid_l;
      more     = lo < mid;
    end
  end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LIS patience-tails unit: a typed table of
// directed samples, then random runs of increasing sequences, repeats, noise
// and one run filling the tail table, scored by typed rows or a local model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import lpt_pkg::*; ();

  localparam int TAIL_DEPTH  = 1024;
  localparam int ITEM_TARGET = 1750;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 40;

  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             ovf;
  } lis_res_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       start;
    logic                       typed;
    lis_res_t                   res;
  } stim_row_t;

  localparam lis_res_t NO_RES = '0;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       start_req;
  logic                       out_valid;
  logic                       out_ready;
  logic [LEN_W-1:0]           lis_length;
  logic                       overflow;

  // Local model of the tail table
  logic signed [SAMPLE_W-1:0] tail_tab [TAIL_DEPTH];
  int                         tail_len;
  logic                       ovf_seen;

  lis_res_t  pending_results [$];
  stim_row_t stim_rows [$];

  int   items_sent;
  int   results_seen;
  int   err_count;
  int   peak_len;
  int   ovf_results;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  logic pressure_go;

  lis_length_patience_tails_unit #(
    .MAX_LEN    (TAIL_DEPTH),
    .VALUE_BITS (SAMPLE_W)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .start_req  (start_req),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .lis_length (lis_length),
    .overflow   (overflow)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Lower-bound placement of one sample; returns length and sticky overflow
  function automatic lis_res_t place_sample(input logic signed [SAMPLE_W-1:0] s,
                                            input logic st);
    int       lo;
    int       hi;
    int       mid;
    lis_res_t r;
    if (st) begin
      tail_len = 0;
      ovf_seen = 1'b0;
    end
    lo = 0;
    hi = tail_len;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tail_tab[mid] < s) lo = mid + 1;
      else hi = mid;
    end
    // equal tail: rewriting the same value changes nothing
    if (lo < tail_len) begin
      tail_tab[lo] = s;
    end else if (tail_len < TAIL_DEPTH) begin
      tail_tab[tail_len] = s;
      tail_len++;
    end else begin
      ovf_seen = 1'b1;
    end
    r.len = LEN_W'(tail_len);
    r.ovf = ovf_seen;
    return r;
  endfunction

  // Offer one input transaction, then log the result it must produce
  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] s, input logic st,
                              input logic typed, input lis_res_t typed_res);
    lis_res_t r;
    // idle mix: sender light / receiver heavy, then swapped, then none
    if (items_sent < 600) begin
      snd_idle_pct = 18;
      rcv_idle_pct = 48;
    end else if (items_sent < 1200) begin
      snd_idle_pct = 48;
      rcv_idle_pct = 18;
    end else begin
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
    end
    if (items_sent == 750) pressure_go <= 1'b1;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample    <= s;
    start_req <= st;
    do @(posedge clk); while (!in_ready);
    r = place_sample(s, st);
    pending_results.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  // Receiver: random ready, plus one long hold-off to back up the input side
  initial begin : receiver
    logic hold_done;
    int   hold;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_go && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        for (hold = 0; hold < HOLD_CYCLES; hold++) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Result scoreboard
  always @(posedge clk) begin : result_check
    lis_res_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (int'(lis_length) > peak_len) peak_len = int'(lis_length);
      if (overflow) ovf_results++;
      if (pending_results.size() == 0) begin
        if (err_count < 10)
          $display("ERROR: unexpected result transaction len=%0d ovf=%0b",
                   lis_length, overflow);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (lis_length !== want.len || overflow !== want.ovf) begin
          if (err_count < 10)
            $display("ERROR: result %0d len exp=%0d act=%0d, ovf exp=%0b act=%0b",
                     results_seen, want.len, lis_length, want.ovf, overflow);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("lis_length_patience_tails_unit regression: fail");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    stim_row_t                  row;
    logic signed [SAMPLE_W-1:0] prev;
    logic signed [SAMPLE_W-1:0] s;
    logic signed [SAMPLE_W-1:0] seq_hist [$];
    longint                     v;
    int                         i;
    int                         pick;
    int                         mode;
    int                         seq_len;
    logic                       long_done;

    rst          = 1'b1;
    in_valid     = 1'b0;
    sample       = '0;
    start_req    = 1'b0;
    pressure_go  = 1'b0;
    tail_len     = 0;
    ovf_seen     = 1'b0;
    items_sent   = 0;
    results_seen = 0;
    err_count    = 0;
    peak_len     = 0;
    ovf_results  = 0;
    snd_idle_pct = 18;
    rcv_idle_pct = 48;
    long_done    = 1'b0;

    // Directed rows: value, start, typed, expected result
    // no start after reset continues from an empty table
    stim_rows.push_back('{S_MIN, 1'b0, 1'b1, '{11'd1, 1'b0}});
    stim_rows.push_back('{S_MIN, 1'b0, 1'b1, '{11'd1, 1'b0}});  // equal tail
    stim_rows.push_back('{S_MAX, 1'b0, 1'b1, '{11'd2, 1'b0}});
    stim_rows.push_back('{S_MAX, 1'b0, 1'b1, '{11'd2, 1'b0}});  // equal tail
    stim_rows.push_back('{32'sd0, 1'b0, 1'b1, '{11'd2, 1'b0}}); // replaces max
    stim_rows.push_back('{-32'sd1, 1'b0, 1'b0, NO_RES});
    stim_rows.push_back('{S_MAX, 1'b0, 1'b0, NO_RES});
    stim_rows.push_back('{32'sd1, 1'b1, 1'b1, '{11'd1, 1'b0}});
    stim_rows.push_back('{32'sd2, 1'b0, 1'b0, NO_RES});
    stim_rows.push_back('{32'sh55555555, 1'b0, 1'b0, NO_RES});
    stim_rows.push_back('{32'shAAAAAAAA, 1'b0, 1'b0, NO_RES});
    stim_rows.push_back('{S_MAX, 1'b1, 1'b1, '{11'd1, 1'b0}});
    stim_rows.push_back('{S_MIN, 1'b0, 1'b1, '{11'd1, 1'b0}});
    stim_rows.push_back('{S_MIN, 1'b1, 1'b1, '{11'd1, 1'b0}});
    stim_rows.push_back('{32'sd100, 1'b0, 1'b0, NO_RES});
    stim_rows.push_back('{32'sd50, 1'b0, 1'b0, NO_RES});
    stim_rows.push_back('{32'sd75, 1'b0, 1'b0, NO_RES});
    stim_rows.push_back('{32'sd75, 1'b0, 1'b0, NO_RES});
    stim_rows.push_back('{32'sd200, 1'b0, 1'b0, NO_RES});
    stim_rows.push_back('{32'sd60, 1'b0, 1'b0, NO_RES});
    stim_rows.push_back('{S_MAX, 1'b0, 1'b0, NO_RES});
    stim_rows.push_back('{32'sh80000001, 1'b0, 1'b0, NO_RES});
    stim_rows.push_back('{32'shFFFFFFFE, 1'b0, 1'b0, NO_RES});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[k]) begin
      row = stim_rows[k];
      offer_sample(row.value, row.start, row.typed, row.res);
    end

    // Random part
    while (items_sent < ITEM_TARGET) begin
      if (!long_done && items_sent >= 250) begin
        // fill the table to its depth with a jittered ramp whose last samples wrap low
        long_done = 1'b1;
        for (i = 0; i < TAIL_DEPTH + 6; i++) begin
          v = -64'sd2147483648 + longint'(i) * 64'sd2097152
              + longint'($urandom_range(2097151, 0));
          offer_sample(v[SAMPLE_W-1:0], i == 0, 1'b0, NO_RES);
        end
        offer_sample(S_MAX, 1'b0, 1'b0, NO_RES);
        repeat (5) offer_sample($urandom, 1'b0, 1'b0, NO_RES);
        continue;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        // new sequence, mostly rising, with repeats and stray values
        seq_len = $urandom_range(40, 3);
        prev = ($urandom_range(9) == 0) ? S_MIN : $urandom;
        seq_hist.delete();
        for (i = 0; i < seq_len; i++) begin
          mode = $urandom_range(99);
          if (i == 0) begin
            v = longint'(prev);
          end else if (mode < 60) begin
            v = longint'(prev) + longint'($urandom_range(
                  ($urandom_range(1) != 0) ? 32'hFF : 32'h00FFFFFF, 1));
            if (v > 64'sd2147483647) v = 64'sd2147483647;
          end else if (mode < 75) begin
            v = longint'(seq_hist[$urandom_range(seq_hist.size() - 1)]);
          end else begin
            v = longint'($urandom);
          end
          s = v[SAMPLE_W-1:0];
          offer_sample(s, i == 0, 1'b0, NO_RES);
          prev = s;
          seq_hist.push_back(s);
        end
      end else if (pick < 90) begin
        // noise, seldom restarting
        repeat ($urandom_range(10, 1))
          offer_sample($urandom, $urandom_range(9) == 0, 1'b0, NO_RES);
      end else begin
        // extremes
        repeat ($urandom_range(6, 1)) begin
          case ($urandom_range(4))
            0: s = S_MIN;
            1: s = S_MAX;
            2: s = -32'sd1;
            3: s = 32'sd0;
            default: s = $urandom;
          endcase
          offer_sample(s, $urandom_range(3) == 0, 1'b0, NO_RES);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d samples and %0d results; longest length %0d.",
             items_sent, results_seen, peak_len);
    $display("Saturated results seen: %0d; mismatches: %0d.", ovf_results, err_count);
    if (err_count == 0) begin
      $display("lis_length_patience_tails_unit regression: pass");
    end else begin
      $display("lis_length_patience_tails_unit regression: fail");
    end
    $finish;
  end

endmodule
